[hdl/vn_pkg.sv]
package vn_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COMP_WIDTH = 32;
  localparam int OUT_WIDTH  = FRAC_BITS + 2;
  localparam int DIM_WIDTH  = 3;
  localparam int LANES      = 4;

  // magnitude of a component, its square, and the sum over all lanes
  localparam int MAG_W = COMP_WIDTH;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int REM_W = SUM_W + 1;
  // quotient c^2 * 2^(2F) / S lies in [0, 2^(2F)], its root in [0, 2^F]
  localparam int Q_W   = 2 * FRAC_BITS + 1;
  localparam int R_W   = FRAC_BITS + 1;
  localparam int SR_W  = Q_W + 2;

  // front (abs + square), merge (two adds), divide, root, sign
  localparam int DEPTH = 2 + 2 + Q_W + R_W + 1;

  localparam logic [DIM_WIDTH-1:0] DIM_MIN   = DIM_WIDTH'(2);
  localparam logic [DIM_WIDTH-1:0] DIM_MAX   = DIM_WIDTH'(4);
  localparam logic [DIM_WIDTH-1:0] DIM_RESET = DIM_WIDTH'(3);

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [OUT_WIDTH-1:0]  norm_t;
  typedef logic [DIM_WIDTH-1:0]         dim_t;
  typedef logic [SQ_W-1:0]              sq_t;
  typedef logic [SUM_W-1:0]             sum_t;

  typedef struct packed {
    logic neg;
    logic live;
  } lane_tag_t;

  // clamp the register to the supported range of 2..4 components
  function automatic dim_t clamp_dim(dim_t d);
    dim_t r;
    r = d;
    if (d < DIM_MIN) r = DIM_MIN;
    if (d > DIM_MAX) r = DIM_MAX;
    return r;
  endfunction

endpackage

[hdl/vn_if.sv]
interface vn_in_if;
  logic         valid;
  logic         ready;
  vn_pkg::comp_t comp_x;
  vn_pkg::comp_t comp_y;
  vn_pkg::comp_t comp_z;
  vn_pkg::comp_t comp_w;
  modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface vn_out_if;
  logic         valid;
  logic         ready;
  vn_pkg::norm_t norm_x;
  vn_pkg::norm_t norm_y;
  vn_pkg::norm_t norm_z;
  vn_pkg::norm_t norm_w;
  modport source (output valid, norm_x, norm_y, norm_z, norm_w, input ready);
  modport sink   (input valid, norm_x, norm_y, norm_z, norm_w, output ready);
endinterface

interface vn_cfg_if;
  logic        valid;
  logic        ready;
  vn_pkg::dim_t dimension;
  modport source (output valid, dimension, input ready);
  modport sink   (input valid, dimension, output ready);
endinterface

[hdl/vn_square.sv]
module vn_square (
  input  logic              clk,
  input  logic              en,
  input  vn_pkg::comp_t     comp,
  input  logic              used,
  output vn_pkg::sq_t       sq,
  output vn_pkg::lane_tag_t tag
);

  logic [vn_pkg::MAG_W-1:0] mag_r;
  logic                     neg_r;
  logic                     used_r;
  vn_pkg::sq_t              sq_r;
  vn_pkg::lane_tag_t        tag_r;

  // take the absolute value; the most negative code maps onto 2^(W-1)
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= comp[vn_pkg::COMP_WIDTH-1];
      mag_r  <= comp[vn_pkg::COMP_WIDTH-1] ? vn_pkg::MAG_W'(-comp) : vn_pkg::MAG_W'(comp);
      used_r <= used;
    end
  end

  // square the magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r     <= vn_pkg::SQ_W'(mag_r) * vn_pkg::SQ_W'(mag_r);
      tag_r.neg  <= neg_r;
      tag_r.live <= used_r && (mag_r != '0);
    end
  end

  assign sq  = sq_r;
  assign tag = tag_r;

endmodule

[hdl/vn_merge.sv]
module vn_merge (
  input  logic              clk,
  input  logic              en,
  input  vn_pkg::sq_t       sq_in  [vn_pkg::LANES],
  input  vn_pkg::lane_tag_t tag_in [vn_pkg::LANES],
  output vn_pkg::sq_t       sq_out [vn_pkg::LANES],
  output vn_pkg::lane_tag_t tag_out[vn_pkg::LANES],
  output vn_pkg::sum_t      sum
);

  logic [vn_pkg::SQ_W:0] pair_r [2];
  vn_pkg::sq_t           sq_d1_r [vn_pkg::LANES];
  vn_pkg::sq_t           sq_d2_r [vn_pkg::LANES];
  vn_pkg::lane_tag_t     tag_d1_r[vn_pkg::LANES];
  vn_pkg::lane_tag_t     tag_d2_r[vn_pkg::LANES];
  vn_pkg::sum_t          sum_r;
  vn_pkg::sum_t          sum_nxt;
  vn_pkg::sq_t           masked  [vn_pkg::LANES];

  // drop squares of lanes out of use
  always_comb begin
    for (int i = 0; i < vn_pkg::LANES; i++) begin
      masked[i] = tag_in[i].live ? sq_in[i] : '0;
    end
  end

  // add pairs, then the total; floor the total at one LSB
  always_comb begin
    sum_nxt = vn_pkg::SUM_W'(pair_r[0]) + vn_pkg::SUM_W'(pair_r[1]);
    if (sum_nxt == '0) sum_nxt = vn_pkg::SUM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair_r[0] <= {1'b0, masked[0]} + {1'b0, masked[1]};
      pair_r[1] <= {1'b0, masked[2]} + {1'b0, masked[3]};
      sum_r     <= sum_nxt;
      sq_d1_r   <= sq_in;
      sq_d2_r   <= sq_d1_r;
      tag_d1_r  <= tag_in;
      tag_d2_r  <= tag_d1_r;
    end
  end

  assign sq_out  = sq_d2_r;
  assign tag_out = tag_d2_r;
  assign sum     = sum_r;

endmodule

[hdl/vn_lane.sv]
module vn_lane (
  input  logic              clk,
  input  logic              en,
  input  vn_pkg::sq_t       sq,
  input  vn_pkg::sum_t      sum,
  input  vn_pkg::lane_tag_t tag,
  output vn_pkg::norm_t     norm
);

  localparam int QW = vn_pkg::Q_W;
  localparam int RW = vn_pkg::R_W;

  logic [vn_pkg::SUM_W-1:0] rem_r  [QW];
  logic [QW-1:0]            quo_r  [QW];
  vn_pkg::sum_t             div_s_r[QW];
  vn_pkg::lane_tag_t        div_t_r[QW];

  logic [vn_pkg::SR_W-1:0]  sr_rem_r [RW];
  logic [RW-1:0]            sr_root_r[RW];
  vn_pkg::lane_tag_t        sr_t_r   [RW];

  vn_pkg::norm_t            norm_r;

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [vn_pkg::REM_W-1:0] trial;
    logic [vn_pkg::REM_W-1:0] dvs;
    logic                     ge;
    logic [QW-1:0]            quo_prev;
    vn_pkg::sum_t             s_in;
    vn_pkg::lane_tag_t        t_in;

    if (k == 0) begin : g_first
      assign trial    = vn_pkg::REM_W'(sq);
      assign quo_prev = '0;
      assign s_in     = sum;
      assign t_in     = tag;
    end else begin : g_next
      assign trial    = {rem_r[k-1], 1'b0};
      assign quo_prev = quo_r[k-1];
      assign s_in     = div_s_r[k-1];
      assign t_in     = div_t_r[k-1];
    end

    assign dvs = vn_pkg::REM_W'(s_in);
    assign ge  = trial >= dvs;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]   <= vn_pkg::SUM_W'(ge ? trial - dvs : trial);
        quo_r[k]   <= {quo_prev[QW-2:0], ge};
        div_s_r[k] <= s_in;
        div_t_r[k] <= t_in;
      end
    end
  end

  // digit-by-digit square root, one root bit per stage
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int B = RW - 1 - j;
    logic [vn_pkg::SR_W-1:0] x_in;
    logic [RW-1:0]           root_in;
    vn_pkg::lane_tag_t       t_in;
    logic [vn_pkg::SR_W-1:0] test;
    logic                    ge;

    if (j == 0) begin : g_first
      assign x_in    = vn_pkg::SR_W'(quo_r[QW-1]);
      assign root_in = '0;
      assign t_in    = div_t_r[QW-1];
    end else begin : g_next
      assign x_in    = sr_rem_r[j-1];
      assign root_in = sr_root_r[j-1];
      assign t_in    = sr_t_r[j-1];
    end

    assign test = (vn_pkg::SR_W'(root_in) << (B + 1)) + (vn_pkg::SR_W'(1) << (2 * B));
    assign ge   = x_in >= test;

    always_ff @(posedge clk) begin
      if (en) begin
        sr_rem_r[j]  <= ge ? x_in - test : x_in;
        sr_root_r[j] <= ge ? (root_in | (RW'(1) << B)) : root_in;
        sr_t_r[j]    <= t_in;
      end
    end
  end

  // apply the sign; zero lanes out of use
  always_ff @(posedge clk) begin
    if (en) begin
      if (!sr_t_r[RW-1].live) begin
        norm_r <= '0;
      end else if (sr_t_r[RW-1].neg) begin
        norm_r <= -vn_pkg::norm_t'({1'b0, sr_root_r[RW-1]});
      end else begin
        norm_r <= vn_pkg::norm_t'({1'b0, sr_root_r[RW-1]});
      end
    end
  end

  assign norm = norm_r;

endmodule

[hdl/vector_normalize.sv]
// Unit vector of a two- to four-component signed Q16.16 vector. Each request
// carries four components; the dimension register (2..4, reset 3, values
// outside clamped) selects how many are used, and unused results are zero.
// Each result is the component divided by the root of the exact sum of
// squares, truncated toward zero, in [-1.0, 1.0]; a zero vector gives zero.
// Four lanes square and divide side by side. The block takes one request per
// clock while the output is not stalled; each passes through registered stages
// for abs and square, the sum, the bit-per-stage division, the root and the
// sign. When the result is not taken the whole pipeline holds. Configuration
// writes are always accepted and should be made with the pipeline empty.
module vector_normalize (
  input  logic      clk,
  input  logic      rst_n,
  vn_in_if.sink     in_ch,
  vn_out_if.source  out_ch,
  vn_cfg_if.sink    cfg_ch
);

  localparam int L = vn_pkg::LANES;

  vn_pkg::dim_t      dim_r;
  logic [vn_pkg::DEPTH-1:0] vld_r;
  logic              en;
  vn_pkg::dim_t      used_n;
  vn_pkg::comp_t     comp  [L];
  vn_pkg::sq_t       sq_a  [L];
  vn_pkg::lane_tag_t tag_a [L];
  vn_pkg::sq_t       sq_b  [L];
  vn_pkg::lane_tag_t tag_b [L];
  vn_pkg::sum_t      sum;
  vn_pkg::norm_t     norm  [L];

  // hold the dimension register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= vn_pkg::DIM_RESET;
    end else if (cfg_ch.valid) begin
      dim_r <= cfg_ch.dimension;
    end
  end
  assign cfg_ch.ready = 1'b1;

  // advance unless a finished result is stalled at the output
  assign en          = !vld_r[vn_pkg::DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[vn_pkg::DEPTH-2:0], in_ch.valid};
    end
  end

  assign used_n  = vn_pkg::clamp_dim(dim_r);
  assign comp[0] = in_ch.comp_x;
  assign comp[1] = in_ch.comp_y;
  assign comp[2] = in_ch.comp_z;
  assign comp[3] = in_ch.comp_w;

  for (genvar i = 0; i < L; i++) begin : g_front
    vn_square u_square (
      .clk  (clk),
      .en   (en),
      .comp (comp[i]),
      .used (vn_pkg::DIM_WIDTH'(i) < used_n),
      .sq   (sq_a[i]),
      .tag  (tag_a[i])
    );
  end

  vn_merge u_merge (
    .clk     (clk),
    .en      (en),
    .sq_in   (sq_a),
    .tag_in  (tag_a),
    .sq_out  (sq_b),
    .tag_out (tag_b),
    .sum     (sum)
  );

  for (genvar i = 0; i < L; i++) begin : g_lane
    vn_lane u_lane (
      .clk  (clk),
      .en   (en),
      .sq   (sq_b[i]),
      .sum  (sum),
      .tag  (tag_b[i]),
      .norm (norm[i])
    );
  end

  assign out_ch.valid  = vld_r[vn_pkg::DEPTH-1];
  assign out_ch.norm_x = norm[0];
  assign out_ch.norm_y = norm[1];
  assign out_ch.norm_z = norm[2];
  assign out_ch.norm_w = norm[3];

endmodule
